>>> design/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types, codes and helpers shared by the SD SPI-mode command engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0]  FILL_BYTE        = 8'hFF;
  localparam logic [7:0]  TOKEN_BASE       = 8'h40;
  localparam logic [7:0]  CRC_POLY         = 8'h09;
  localparam logic [7:0]  R1_LIMIT_RESET   = 8'd7;
  localparam logic [23:0] BUSY_LIMIT_RESET = 24'd200000;

  localparam logic CFG_R1_LIMIT   = 1'b0;
  localparam logic CFG_BUSY_LIMIT = 1'b1;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_RECEIVE = 1'b1;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_R1_TIMEOUT   = 3'd1;
  localparam logic [2:0] ST_CRC_ERROR    = 3'd2;
  localparam logic [2:0] ST_ILLEGAL_CMD  = 3'd3;
  localparam logic [2:0] ST_OTHER_ERROR  = 3'd4;
  localparam logic [2:0] ST_BUSY_TIMEOUT = 3'd5;

  localparam int unsigned FLAG_BUSY = 0;
  localparam int unsigned FLAG_R8   = 1;
  localparam int unsigned FLAG_R32  = 2;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic        want_busy;
    logic        want_r8;
    logic        want_r32;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] response;
  } rsp_t;

  typedef struct packed {
    logic        start;
    logic [39:0] frame;
    logic [2:0]  flags;
    logic [7:0]  rx_byte;
  } op_t;

  typedef struct packed {
    logic push;
  } qctl_t;

  function automatic logic [7:0] crc7_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] v;
    c = crc_in;
    v = data;
    for (int i = 0; i < 8; i++) begin
      c = {c[6:0], 1'b0};
      if (v[7] ^ c[7]) begin
        c = c ^ CRC_POLY;
      end
      v = {v[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> design/sdspi_front.sv
// ----------------------------------------------------------------------------
// sdspi_front
// Accepts request transactions, classifies them into start and receive
// operations, builds the command frame header and pushes into the queue.
// ----------------------------------------------------------------------------
module sdspi_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  sdspi_pkg::req_t     req,
  output sdspi_pkg::qctl_t    qctl,
  input  logic                q_full,
  output sdspi_pkg::op_t      op
);

  logic op_valid;
  logic accept;

  assign req_stall  = op_valid && q_full;
  assign accept     = req_valid && !req_stall;
  assign qctl.push  = op_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (accept) begin
      op_valid <= 1'b1;
    end else if (qctl.push) begin
      op_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op.start   <= (req.cmd == sdspi_pkg::CMD_START);
      op.frame   <= {sdspi_pkg::TOKEN_BASE | {2'b00, req.cmd_index}, req.argument};
      op.flags   <= {req.want_r32, req.want_r8, req.want_busy};
      op.rx_byte <= req.rx_byte;
    end
  end

endmodule

>>> design/sdspi_queue.sv
// ----------------------------------------------------------------------------
// sdspi_queue
// Short operation queue between the front and back parts.
// ----------------------------------------------------------------------------
module sdspi_queue (
  input  logic                clk,
  input  logic                rst,
  input  sdspi_pkg::qctl_t    qctl,
  input  sdspi_pkg::op_t      wr_op,
  output logic                q_full,
  output logic                q_valid,
  output sdspi_pkg::op_t      rd_op,
  input  logic                pop
);

  sdspi_pkg::op_t mem [sdspi_pkg::QDEPTH];
  logic [sdspi_pkg::QPTR_W-1:0] wr_ptr;
  logic [sdspi_pkg::QPTR_W-1:0] rd_ptr;
  logic [sdspi_pkg::QCNT_W-1:0] count;
  logic do_pop;

  assign q_full  = (count == sdspi_pkg::QCNT_W'(sdspi_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign rd_op   = mem[rd_ptr];
  assign do_pop  = pop && q_valid;

  function automatic logic [sdspi_pkg::QPTR_W-1:0] ptr_inc(input logic [sdspi_pkg::QPTR_W-1:0] p);
    if (p == sdspi_pkg::QPTR_W'(sdspi_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (qctl.push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (qctl.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!qctl.push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (qctl.push) begin
      mem[wr_ptr] <= wr_op;
    end
  end

endmodule

>>> design/sdspi_back.sv
// ----------------------------------------------------------------------------
// sdspi_back
// Carries out queued operations: emits the command frame with CRC7 one byte
// per cycle unless stalled, then walks the response phases per received byte.
// ----------------------------------------------------------------------------
module sdspi_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                q_valid,
  input  sdspi_pkg::op_t      q_op,
  output logic                pop,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output sdspi_pkg::rsp_t     rsp
);

  typedef enum logic [6:0] {
    PH_IDLE         = 7'b0000001,
    PH_SKIP         = 7'b0000010,
    PH_R1           = 7'b0000100,
    PH_BUSY_DISCARD = 7'b0001000,
    PH_BUSY_POLL    = 7'b0010000,
    PH_R8           = 7'b0100000,
    PH_R32          = 7'b1000000
  } phase_t;

  logic [7:0]  r1_limit;
  logic [23:0] busy_limit;

  phase_t      phase, phase_next;
  logic [23:0] poll_count, poll_count_next;
  logic [7:0]  r1_value, r1_value_next;
  logic [31:0] resp_shift, resp_shift_next;
  logic [2:0]  flags, flags_next;
  logic [39:0] frame, frame_next;
  logic [7:0]  crc, crc_next;
  logic [2:0]  seq, seq_next;
  logic        emit, emit_next;

  sdspi_pkg::rsp_t res;
  logic        load;
  logic        slot_free;
  logic [7:0]  b;
  logic [23:0] poll_inc;
  logic [31:0] shifted;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign b         = q_op.rx_byte;
  assign poll_inc  = poll_count + 24'd1;
  assign shifted   = {resp_shift[23:0], b};

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_limit   <= sdspi_pkg::R1_LIMIT_RESET;
      busy_limit <= sdspi_pkg::BUSY_LIMIT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == sdspi_pkg::CFG_R1_LIMIT) begin
        r1_limit <= cfg_data[7:0];
      end else begin
        busy_limit <= cfg_data;
      end
    end
  end

  always_comb begin
    phase_next      = phase;
    poll_count_next = poll_count;
    r1_value_next   = r1_value;
    resp_shift_next = resp_shift;
    flags_next      = flags;
    frame_next      = frame;
    crc_next        = crc;
    seq_next        = seq;
    emit_next       = emit;
    res             = '0;
    load            = 1'b0;
    pop             = 1'b0;

    if (emit) begin
      if (slot_free) begin
        load         = 1'b1;
        res.tx_valid = 1'b1;
        seq_next     = seq + 3'd1;
        if (seq == 3'd6) begin
          res.tx_byte = {crc[6:0], 1'b1};
        end else if (seq == 3'd7) begin
          res.tx_byte = sdspi_pkg::FILL_BYTE;
          res.last    = 1'b1;
          emit_next   = 1'b0;
        end else begin
          res.tx_byte = frame[39:32];
          frame_next  = {frame[31:0], 8'h00};
          crc_next    = sdspi_pkg::crc7_byte(crc, frame[39:32]);
        end
      end
    end else if (q_valid && slot_free) begin
      pop = 1'b1;
      if (q_op.start) begin
        load            = 1'b1;
        res.tx_valid    = 1'b1;
        res.tx_byte     = sdspi_pkg::FILL_BYTE;
        frame_next      = q_op.frame;
        crc_next        = '0;
        seq_next        = 3'd1;
        emit_next       = 1'b1;
        flags_next      = q_op.flags;
        phase_next      = PH_SKIP;
        poll_count_next = '0;
        r1_value_next   = '0;
        resp_shift_next = '0;
      end else begin
        load         = 1'b1;
        res.tx_valid = 1'b1;
        res.tx_byte  = sdspi_pkg::FILL_BYTE;
        res.last     = 1'b1;
        case (phase)
          PH_SKIP: begin
            phase_next      = PH_R1;
            poll_count_next = '0;
          end
          PH_R1: begin
            if (!b[7]) begin
              r1_value_next = b;
              if (b[3] || b[2] || (b[7:1] != '0)) begin
                res.tx_valid = 1'b0;
                res.tx_byte  = '0;
                res.done_res = 1'b1;
                res.response = {24'h0, b};
                phase_next   = PH_IDLE;
                if (b[3]) begin
                  res.status = sdspi_pkg::ST_CRC_ERROR;
                end else if (b[2]) begin
                  res.status = sdspi_pkg::ST_ILLEGAL_CMD;
                end else begin
                  res.status = sdspi_pkg::ST_OTHER_ERROR;
                end
              end else if (flags[sdspi_pkg::FLAG_BUSY]) begin
                phase_next      = PH_BUSY_DISCARD;
                poll_count_next = '0;
              end else begin
                poll_count_next = '0;
                if (flags[sdspi_pkg::FLAG_R8]) begin
                  phase_next = PH_R8;
                end else if (flags[sdspi_pkg::FLAG_R32]) begin
                  phase_next      = PH_R32;
                  resp_shift_next = '0;
                end else begin
                  res.tx_valid = 1'b0;
                  res.tx_byte  = '0;
                  res.done_res = 1'b1;
                  res.status   = sdspi_pkg::ST_OK;
                  res.response = {24'h0, b};
                  phase_next   = PH_IDLE;
                end
              end
            end else begin
              poll_count_next = poll_inc;
              if (poll_inc >= {16'h0, r1_limit}) begin
                res.tx_valid = 1'b0;
                res.tx_byte  = '0;
                res.done_res = 1'b1;
                res.status   = sdspi_pkg::ST_R1_TIMEOUT;
                res.response = {24'h0, b};
                phase_next   = PH_IDLE;
              end
            end
          end
          PH_BUSY_DISCARD: begin
            poll_count_next = poll_inc;
            if (poll_inc >= 24'd2) begin
              phase_next      = PH_BUSY_POLL;
              poll_count_next = '0;
            end
          end
          PH_BUSY_POLL: begin
            if (poll_count >= busy_limit) begin
              res.tx_valid = 1'b0;
              res.tx_byte  = '0;
              res.done_res = 1'b1;
              res.status   = sdspi_pkg::ST_BUSY_TIMEOUT;
              res.response = {24'h0, r1_value};
              phase_next   = PH_IDLE;
            end else if (b == sdspi_pkg::FILL_BYTE) begin
              poll_count_next = '0;
              if (flags[sdspi_pkg::FLAG_R8]) begin
                phase_next = PH_R8;
              end else if (flags[sdspi_pkg::FLAG_R32]) begin
                phase_next      = PH_R32;
                resp_shift_next = '0;
              end else begin
                res.tx_valid = 1'b0;
                res.tx_byte  = '0;
                res.done_res = 1'b1;
                res.status   = sdspi_pkg::ST_OK;
                res.response = {24'h0, r1_value};
                phase_next   = PH_IDLE;
              end
            end else begin
              poll_count_next = poll_inc;
            end
          end
          PH_R8: begin
            resp_shift_next = {24'h0, b};
            if (flags[sdspi_pkg::FLAG_R32]) begin
              phase_next      = PH_R32;
              poll_count_next = '0;
            end else begin
              res.tx_valid = 1'b0;
              res.tx_byte  = '0;
              res.done_res = 1'b1;
              res.status   = sdspi_pkg::ST_OK;
              res.response = {24'h0, b};
              phase_next   = PH_IDLE;
            end
          end
          PH_R32: begin
            resp_shift_next = shifted;
            poll_count_next = poll_inc;
            if (poll_inc >= 24'd4) begin
              res.tx_valid = 1'b0;
              res.tx_byte  = '0;
              res.done_res = 1'b1;
              res.status   = sdspi_pkg::ST_OK;
              res.response = shifted;
              phase_next   = PH_IDLE;
            end
          end
          default: begin
            // receive while idle: dropped
            load       = 1'b0;
            res        = '0;
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      poll_count <= '0;
      r1_value   <= '0;
      resp_shift <= '0;
      flags      <= '0;
      crc        <= '0;
      seq        <= '0;
      emit       <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      poll_count <= poll_count_next;
      r1_value   <= r1_value_next;
      resp_shift <= resp_shift_next;
      flags      <= flags_next;
      crc        <= crc_next;
      seq        <= seq_next;
      emit       <= emit_next;
      if (slot_free) begin
        rsp_valid <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    frame <= frame_next;
    if (slot_free && load) begin
      rsp <= res;
    end
  end

  a_no_pop_while_emit: assert property (@(posedge clk) disable iff (rst)
    emit |-> !pop)
    else $error("queue popped during frame emission");

  a_emit_seq_nonzero: assert property (@(posedge clk) disable iff (rst)
    emit |-> (seq != 3'd0))
    else $error("frame sequence counter out of step");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (load && res.done_res) |=> (phase == PH_IDLE) && !emit)
    else $error("exchange finished but phase not idle");

  a_done_no_tx: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.done_res) |-> (!rsp.tx_valid && (rsp.tx_byte == 8'h00)))
    else $error("done result carries a transmit byte");

  a_emit_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && load && res.last) |=> !emit && (phase == PH_SKIP))
    else $error("frame emission did not end in skip phase");

endmodule

>>> design/sd_spi_command_engine.sv
// ----------------------------------------------------------------------------
// sd_spi_command_engine
// SD card SPI-mode command engine: sends a command frame with CRC7 and
// runs the R1 poll, busy wait and optional R8/R32 read one byte at a time.
//
//   channel   signals                         direction
//   req       req_valid, req_stall, req       into the block
//   rsp       rsp_valid, rsp_stall, rsp       out of the block
//   cfg       cfg_write, cfg_index, cfg_data  into the block
//
// a receive transaction passes the front register and then the queue before
// its result is offered, one per cycle unless stalled or a start is emitting
// a start yields eight results, one per cycle unless stalled, from the byte
// sequencer in the back part, which holds the queue during that time
// front register plus a two-entry queue absorb rsp_stall before req_stall rises
// reset is synchronous; the engine comes up idle with the default poll limits
// ----------------------------------------------------------------------------
module sd_spi_command_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  sdspi_pkg::req_t     req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output sdspi_pkg::rsp_t     rsp,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data
);

  sdspi_pkg::qctl_t qctl;
  sdspi_pkg::op_t   wr_op;
  sdspi_pkg::op_t   rd_op;
  logic             q_full;
  logic             q_valid;
  logic             pop;

  sdspi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .qctl      (qctl),
    .q_full    (q_full),
    .op        (wr_op)
  );

  sdspi_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .qctl    (qctl),
    .wr_op   (wr_op),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rd_op   (rd_op),
    .pop     (pop)
  );

  sdspi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_op      (rd_op),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
